// ----- src/d2h_pkg.sv -----
// shared types and constants for the double to hex float converter
// no dependencies
`default_nettype none
package d2h_pkg;
	localparam int unsigned DBL_W = 64;
	localparam int unsigned FRAC_W = 52;
	localparam int unsigned BEXP_W = 11;
	localparam int unsigned HFRAC_W = 56;
	localparam int unsigned LZ_W = 6;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_WRAP = 2'd1;
	localparam logic [1:0] ST_NAN  = 2'd2;

	localparam logic [BEXP_W-1:0] BEXP_MAX = 11'h7FF;

	typedef struct packed {
		logic [DBL_W-1:0] word;
		logic [1:0]       status;
	} d2h_result_t;
endpackage
`default_nettype wire

// ----- src/double_to_hex_float_real8.sv -----
// channel | handshake                | payload
// in      | in_valid / in_ready      | double_bits
// out     | out_valid / out_ready    | real8_bits, status
// one word per cycle sustained while out_ready is high; a word passes through the input
// register, the conversion logic and the result register
// arst_n clears both stage valid flags; payload registers are not reset
// a stalled result holds in the result register while the input register
// still takes a word if it is empty or moving forward
`default_nettype none
module double_to_hex_float_real8 (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [d2h_pkg::DBL_W-1:0]  double_bits,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [d2h_pkg::DBL_W-1:0]       real8_bits,
	output logic [1:0]                      status
);
	import d2h_pkg::*;

	logic             v_s1, v_s2;
	logic [DBL_W-1:0] bits_s1;
	d2h_result_t      res;
	d2h_result_t      res_s2;
	logic             adv;

	assign adv      = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv;

	d2h_conv u_conv (
		.bits(bits_s1),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) bits_s1 <= double_bits;
		if (adv && v_s1) res_s2 <= res;
	end

	assign out_valid  = v_s2;
	assign real8_bits = res_s2.word;
	assign status     = res_s2.status;

	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NAN) |-> (real8_bits == '0))
		else $error("nan word not zero");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && real8_bits != '0) |-> (real8_bits[55:52] != 4'd0))
		else $error("fraction not normalized");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_WRAP || status == ST_NAN))
		else $error("bad status");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted word lost");
endmodule
`default_nettype wire

// ----- src/d2h_lzc.sv -----
// leading zero count of the 52-bit trailing significand
// uses d2h_pkg
`default_nettype none
module d2h_lzc (
	input  wire logic [d2h_pkg::FRAC_W-1:0] frac,
	output logic [d2h_pkg::LZ_W-1:0]        lz
);
	import d2h_pkg::*;

	always_comb begin
		lz = LZ_W'(FRAC_W);
		// highest set bit is assigned last and wins
		for (int i = 0; i < FRAC_W; i++) begin
			if (frac[i]) begin
				lz = LZ_W'(FRAC_W - 1 - i);
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/d2h_conv.sv -----
// combinational binary64 to hex float conversion
// uses d2h_pkg and d2h_lzc
`default_nettype none
module d2h_conv (
	input  wire logic [d2h_pkg::DBL_W-1:0] bits,
	output d2h_pkg::d2h_result_t           res
);
	import d2h_pkg::*;

	logic                    sign;
	logic [BEXP_W-1:0]       bexp;
	logic [FRAC_W-1:0]       frac;
	logic [LZ_W-1:0]         lz;
	logic                    is_sub;
	logic [FRAC_W:0]         mag;
	logic [LZ_W-1:0]         bl;
	logic signed [11:0]      p;
	logic signed [11:0]      h;
	logic signed [11:0]      hexp;
	logic signed [11:0]      neg_p;
	logic [LZ_W-1:0]         sh;
	logic [HFRAC_W-1:0]      hfrac;
	logic                    wrap;

	assign sign = bits[63];
	assign bexp = bits[62:52];
	assign frac = bits[FRAC_W-1:0];

	d2h_lzc u_lzc (
		.frac(frac),
		.lz  (lz)
	);

	always_comb begin
		is_sub = (bexp == '0);
		mag    = is_sub ? {1'b0, frac} : {1'b1, frac};
		bl     = is_sub ? (6'd52 - lz) : 6'd53;
		// binary magnitude lies in [2^(p-1), 2^p)
		p      = is_sub ? ($signed({6'b0, bl}) - 12'sd1074)
		                : ($signed({1'b0, bexp}) - 12'sd1022);
		h      = (p + 12'sd3) >>> 2;
		hexp   = h + 12'sd64;
		neg_p  = -p;
		sh     = 6'd56 - bl - {4'b0, neg_p[1:0]};
		hfrac  = {3'b0, mag} << sh;
		wrap   = (hexp < 12'sd0) || (hexp > 12'sd127);
		if (bexp == BEXP_MAX) begin
			res.word   = '0;
			res.status = ST_NAN;
		end else if (is_sub && (frac == '0)) begin
			res.word   = '0;
			res.status = ST_OK;
		end else begin
			res.word   = {sign, hexp[6:0], hfrac};
			res.status = wrap ? ST_WRAP : ST_OK;
		end
	end
endmodule
`default_nettype wire
